FILE: design/modbus_tcp_packet_filter_core_defines.svh
// Assertion macros for the Modbus/TCP packet filter.
// Used by modbus_tcp_packet_filter_core.sv; no other dependencies.
`ifndef MODBUS_TCP_PACKET_FILTER_CORE_DEFINES_SVH
`define MODBUS_TCP_PACKET_FILTER_CORE_DEFINES_SVH
`ifndef SYNTH
// prop must hold at every rising clock edge outside reset
`define MTPF_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// expr must never be true outside reset
`define MTPF_ASSERT_NEVER(lbl, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(expr)) else $error(msg);
`else
`define MTPF_ASSERT(lbl, prop, msg)
`define MTPF_ASSERT_NEVER(lbl, expr, msg)
`endif
`endif

FILE: design/mtpf_pkg.sv
// Package for the Modbus/TCP packet filter: codes, reasons, helpers.
// No dependencies.
`timescale 1ns / 1ps
package mtpf_pkg;

   // function codes
   localparam logic [7:0] FC_READ_COILS       = 8'h01;
   localparam logic [7:0] FC_READ_DISCRETE    = 8'h02;
   localparam logic [7:0] FC_READ_HOLDING     = 8'h03;
   localparam logic [7:0] FC_READ_INPUT       = 8'h04;
   localparam logic [7:0] FC_WRITE_COIL       = 8'h05;
   localparam logic [7:0] FC_WRITE_REG        = 8'h06;
   localparam logic [7:0] FC_READ_EXC_STATUS  = 8'h07;
   localparam logic [7:0] FC_DIAGNOSTIC       = 8'h08;
   localparam logic [7:0] FC_GET_COMM_COUNTER = 8'h0B;
   localparam logic [7:0] FC_GET_COMM_LOG     = 8'h0C;
   localparam logic [7:0] FC_WRITE_COILS      = 8'h0F;
   localparam logic [7:0] FC_WRITE_REGS       = 8'h10;
   localparam logic [7:0] FC_REPORT_SERVER_ID = 8'h11;
   localparam logic [7:0] FC_READ_FILE_RECORD = 8'h14;
   localparam logic [7:0] FC_WRITE_FILE_RECORD = 8'h15;
   localparam logic [7:0] FC_MASK_WRITE_REG   = 8'h16;
   localparam logic [7:0] FC_READ_WRITE_MULTI = 8'h17;
   localparam logic [7:0] FC_READ_FIFO        = 8'h18;
   localparam logic [7:0] FC_MEI              = 8'h2B;
   localparam logic [7:0] FC_MASK_LAST        = 8'h80;

   // MEI types
   localparam logic [7:0] MEI_CANOPEN   = 8'h0D;
   localparam logic [7:0] MEI_DEVICE_ID = 8'h0E;

   // configuration register indexes
   localparam logic [1:0] CSR_MASK_LOW  = 2'd0;
   localparam logic [1:0] CSR_MASK_HIGH = 2'd1;
   localparam logic [1:0] CSR_ADDR_MIN  = 2'd2;
   localparam logic [1:0] CSR_ADDR_MAX  = 2'd3;

   // verdict reasons
   typedef enum logic [2:0] {
      RSN_NONE     = 3'd0,
      RSN_SHORT    = 3'd1,
      RSN_PROTO_ID = 3'd2,
      RSN_MBAP_LEN = 3'd3,
      RSN_PDU_LEN  = 3'd4,
      RSN_FUNC     = 3'd5,
      RSN_ADDR     = 3'd6
   } fail_reason_type;

   // byte divisible by seven: octal digit sum, folded twice
   function automatic logic div_by_7(input logic [7:0] x);
      logic [4:0] s1;
      logic [3:0] s2;
      s1 = {3'b0, x[7:6]} + {2'b0, x[5:3]} + {2'b0, x[2:0]};
      s2 = {2'b0, s1[4:3]} + {1'b0, s1[2:0]};
      return (s2 == 4'd0) || (s2 == 4'd7);
   endfunction

   // start >= min and start + qty <= max, no wrap
   function automatic logic range_ok(input logic [15:0] start, input logic [15:0] qty,
                                     input logic [15:0] lo, input logic [15:0] hi);
      logic [16:0] top;
      top = {1'b0, start} + {1'b0, qty};
      return (start >= lo) && (top <= {1'b0, hi});
   endfunction

endpackage

FILE: design/modbus_tcp_packet_filter_core.sv
// Modbus/TCP packet filter: byte-wide inspection with one verdict per packet.
// Depends on mtpf_pkg and modbus_tcp_packet_filter_core_defines.svh.
//
//   channel | ports                          | direction | beat
//   req     | rx_byte, last_byte, resp. dir  | in        | one packet byte
//   rsp     | verdict_fail, reason, fcode    | out       | one verdict per packet
//   csr     | we, index, wdata               | in        | one register write
//
// One byte per cycle: a byte is registered, then parsed and checked in the next cycle.
// A verdict is registered when the last byte leaves the input register and sits in an output register.
// Only a last byte waits on a full output register; other bytes keep flowing.
// Synchronous reset clears the packet state, the valid flags and the configuration registers to their defaults.
`timescale 1ns / 1ps
`include "modbus_tcp_packet_filter_core_defines.svh"
module modbus_tcp_packet_filter_core
   import mtpf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   input  logic        req_last_byte,
   input  logic        req_response_dir,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_verdict_fail,
   output logic [2:0]  rsp_fail_reason,
   output logic [7:0]  rsp_fcode,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_wdata
);

   // configuration
   logic [63:0] mask_low_ff, mask_high_ff;
   logic [15:0] addr_min_ff, addr_max_ff;

   // input register
   logic        s1_valid_ff;
   logic [7:0]  s1_byte_ff;
   logic        s1_last_ff, s1_dir_ff;
   logic        s1_fire;

   // packet state
   logic [15:0] byte_index_ff, byte_index_in;
   logic [15:0] proto_id_ff, proto_id_in;
   logic [15:0] mbap_len_ff, mbap_len_in;
   logic [7:0]  func_code_ff, func_code_in;
   logic [15:0] count_ff, count_in;
   logic [15:0] sub_off_ff, sub_off_in;
   logic [15:0] next_start_ff, next_start_in;
   logic [15:0] rec_len_ff, rec_len_in;
   logic [7:0]  obj_cnt_ff, obj_cnt_in;
   logic        walk_active_ff, walk_active_in;
   logic        walk_match_ff, walk_match_in;
   logic        len_ovf_ff, len_ovf_in;
   logic [15:0] addr_words_ff [4];
   logic [15:0] addr_words_in [4];

   // result register
   logic        rsp_valid_ff;
   logic        verdict_ff;
   logic [2:0]  reason_ff;
   logic [7:0]  fcode_ff;
   fail_reason_type reason_cur;
   logic [7:0]  fcode_cur;

   // handshake: only a last byte needs room in the result register
   assign s1_fire   = s1_valid_ff && (!s1_last_ff || !rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_fire;

   // absorb the registered byte into the packet state
   always_comb begin
      logic [15:0] pos;
      logic [15:0] j;
      logic [7:0]  b;
      logic [7:0]  cnt;
      logic [15:0] rl;
      logic [17:0] nb;
      logic [17:0] cnt18;
      logic [16:0] sum;
      pos = byte_index_ff;
      b   = s1_byte_ff;
      j   = pos - 16'd8;
      byte_index_in  = byte_index_ff;
      proto_id_in    = proto_id_ff;
      mbap_len_in    = mbap_len_ff;
      func_code_in   = func_code_ff;
      count_in       = count_ff;
      sub_off_in     = sub_off_ff;
      next_start_in  = next_start_ff;
      rec_len_in     = rec_len_ff;
      obj_cnt_in     = obj_cnt_ff;
      walk_active_in = walk_active_ff;
      walk_match_in  = walk_match_ff;
      len_ovf_in     = len_ovf_ff;
      for (int k = 0; k < 4; k++) addr_words_in[k] = addr_words_ff[k];
      rl    = {rec_len_ff[7:0], b};
      nb    = {2'b0, next_start_ff} + 18'd7 + {1'b0, rl, 1'b0};
      cnt   = 8'h00;
      cnt18 = 18'd0;
      sum   = {1'b0, next_start_ff} + 17'd2 + {9'b0, b};
      if (len_ovf_ff || (pos == 16'hFFFF)) begin
         len_ovf_in = 1'b1;
      end else begin
         byte_index_in = pos + 16'd1;
         // capture header and PDU fields
         if (pos == 16'd2 || pos == 16'd3) proto_id_in = {proto_id_ff[7:0], b};
         else if (pos == 16'd4 || pos == 16'd5) mbap_len_in = {mbap_len_ff[7:0], b};
         else if (pos == 16'd7) func_code_in = b;
         else if (pos >= 16'd8 && pos <= 16'd15) begin
            if (!pos[0]) addr_words_in[pos[2:1]] = {b, 8'h00};
            else addr_words_in[pos[2:1]] = addr_words_ff[pos[2:1]] | {8'h00, b};
         end else if (pos == 16'd16) count_in = {8'h00, b};
         cnt   = addr_words_in[0][15:8];
         cnt18 = {10'b0, cnt};
         // sub-request and object walks
         if (pos >= 16'd8) begin
            if (func_code_ff == FC_WRITE_FILE_RECORD) begin
               if (j == 16'd0) begin
                  next_start_in  = 16'd0;
                  sub_off_in     = 16'd0;
                  walk_match_in  = 1'b0;
                  walk_active_in = (b >= 8'd7);
               end else if (walk_active_ff) begin
                  if ({1'b0, sub_off_ff} == {1'b0, next_start_ff} + 17'd5) begin
                     rec_len_in = {8'h00, b};
                  end else if ({1'b0, sub_off_ff} == {1'b0, next_start_ff} + 17'd6) begin
                     rec_len_in = rl;
                     if (nb == cnt18) begin
                        walk_match_in  = 1'b1;
                        walk_active_in = 1'b0;
                     end else if (nb > cnt18 || (cnt18 - nb) < 18'd7) begin
                        walk_active_in = 1'b0;
                     end else begin
                        next_start_in = nb[15:0];
                     end
                  end
                  sub_off_in = sub_off_ff + 16'd1;
               end
            end else if (func_code_ff == FC_MEI) begin
               if (j == 16'd0) begin
                  next_start_in = 16'd6;
                  obj_cnt_in    = 8'h00;
               end else if (obj_cnt_ff < addr_words_in[2][7:0] &&
                            {1'b0, j} == {1'b0, next_start_ff} + 17'd1) begin
                  next_start_in = sum[16] ? 16'hFFFF : sum[15:0];
                  obj_cnt_in    = obj_cnt_ff + 8'd1;
               end
            end
         end
      end
   end

   // check the packet as it stands after this byte
   always_comb begin
      logic [16:0] len;
      logic [15:0] p;
      logic [16:0] p17;
      logic [7:0]  d0, d4;
      logic [15:0] aw0, aw1, aw2, aw3;
      logic [127:0] mask;
      logic [7:0]  fc, fc_m1;
      logic        req_len_ok, rsp_len_ok, rejected, addr_ok;
      fc    = func_code_in;
      aw0   = addr_words_in[0];
      aw1   = addr_words_in[1];
      aw2   = addr_words_in[2];
      aw3   = addr_words_in[3];
      d0    = aw0[15:8];
      d4    = aw2[15:8];
      len   = len_ovf_in ? 17'h10000 : {1'b0, byte_index_in};
      p     = byte_index_in - 16'd8;
      p17   = {1'b0, p};
      mask  = {mask_high_ff, mask_low_ff};
      fc_m1 = fc - 8'd1;

      // request PDU lengths
      case (fc) inside
         FC_READ_COILS, FC_READ_DISCRETE, FC_READ_HOLDING, FC_READ_INPUT,
         FC_WRITE_COIL, FC_WRITE_REG, FC_DIAGNOSTIC: req_len_ok = (p == 16'd4);
         FC_READ_EXC_STATUS, FC_GET_COMM_COUNTER, FC_GET_COMM_LOG,
         FC_REPORT_SERVER_ID: req_len_ok = (p == 16'd0);
         FC_WRITE_COILS, FC_WRITE_REGS:
            req_len_ok = (p >= 16'd5) && (p == {8'h00, d4} + 16'd5);
         FC_MASK_WRITE_REG: req_len_ok = (p == 16'd6);
         FC_READ_WRITE_MULTI:
            req_len_ok = (p >= 16'd9) && (p17 == {1'b0, count_in} + 17'd9);
         FC_READ_FIFO: req_len_ok = (p == 16'd2);
         FC_MEI: req_len_ok = (d0 == MEI_DEVICE_ID) && (p == 16'd3);
         FC_READ_FILE_RECORD:
            req_len_ok = (p >= 16'd1) && ({8'h00, d0} == p - 16'd1) && div_by_7(d0);
         FC_WRITE_FILE_RECORD:
            req_len_ok = (p >= 16'd1) && ({8'h00, d0} == p - 16'd1) && walk_match_in;
         default: req_len_ok = 1'b1;
      endcase

      // response PDU lengths
      case (fc) inside
         FC_READ_COILS, FC_READ_DISCRETE, FC_GET_COMM_LOG, FC_READ_WRITE_MULTI:
            rsp_len_ok = (p >= 16'd1) && (p == {8'h00, d0} + 16'd1);
         FC_READ_HOLDING, FC_READ_INPUT:
            rsp_len_ok = (p >= 16'd1) && (p == {7'h00, d0, 1'b0} + 16'd1);
         FC_WRITE_COIL, FC_WRITE_REG, FC_DIAGNOSTIC, FC_GET_COMM_COUNTER,
         FC_WRITE_COILS, FC_WRITE_REGS: rsp_len_ok = (p == 16'd4);
         FC_READ_EXC_STATUS: rsp_len_ok = (p == 16'd1);
         FC_MASK_WRITE_REG: rsp_len_ok = (p == 16'd6);
         FC_READ_FIFO: rsp_len_ok = (p >= 16'd2) && (p17 == {1'b0, aw0} + 17'd2);
         FC_MEI:
            rsp_len_ok = (p >= 16'd6) && ((d0 == MEI_CANOPEN) ||
                         ((d0 == MEI_DEVICE_ID) && (obj_cnt_in == aw2[7:0]) &&
                          (next_start_in == p)));
         default: rsp_len_ok = 1'b1;
      endcase

      // function code mask, codes one through 128 only
      rejected = (fc != 8'h00) && (fc <= FC_MASK_LAST) && mask[fc_m1[6:0]];

      // address windows
      case (fc) inside
         FC_READ_COILS, FC_READ_DISCRETE, FC_READ_HOLDING, FC_READ_INPUT,
         FC_WRITE_COILS, FC_WRITE_REGS:
            addr_ok = range_ok(aw0, aw1, addr_min_ff, addr_max_ff);
         FC_WRITE_COIL, FC_WRITE_REG, FC_MASK_WRITE_REG:
            addr_ok = range_ok(aw0, 16'd0, addr_min_ff, addr_max_ff);
         FC_READ_WRITE_MULTI:
            addr_ok = range_ok(aw0, aw1, addr_min_ff, addr_max_ff) &&
                      range_ok(aw2, aw3, addr_min_ff, addr_max_ff);
         default: addr_ok = 1'b1;
      endcase

      fcode_cur  = fc;
      reason_cur = RSN_NONE;
      if (!len_ovf_in && byte_index_in < 16'd8) begin
         reason_cur = RSN_SHORT;
         fcode_cur  = 8'h00;
      end else if (proto_id_in != 16'd0) reason_cur = RSN_PROTO_ID;
      else if (len_ovf_in || ({1'b0, mbap_len_in} != len - 17'd6)) reason_cur = RSN_MBAP_LEN;
      else if (s1_dir_ff) begin
         if (!rsp_len_ok) reason_cur = RSN_PDU_LEN;
      end else if (!req_len_ok) reason_cur = RSN_PDU_LEN;
      else if (rejected) reason_cur = RSN_FUNC;
      else if (!addr_ok) reason_cur = RSN_ADDR;
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         mask_low_ff  <= 64'd0;
         mask_high_ff <= 64'd0;
         addr_min_ff  <= 16'd0;
         addr_max_ff  <= 16'hFFFF;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_MASK_LOW:  mask_low_ff  <= csr_wdata;
            CSR_MASK_HIGH: mask_high_ff <= csr_wdata;
            CSR_ADDR_MIN:  addr_min_ff  <= csr_wdata[15:0];
            CSR_ADDR_MAX:  addr_max_ff  <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_valid && req_ready) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_fire) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_byte_ff <= req_rx_byte;
         s1_last_ff <= req_last_byte;
         s1_dir_ff  <= req_response_dir;
      end
   end

   // packet state: advance on each byte, clear after the last
   always_ff @(posedge clock) begin
      if (reset || (s1_fire && s1_last_ff)) begin
         byte_index_ff  <= 16'd0;
         proto_id_ff    <= 16'd0;
         mbap_len_ff    <= 16'd0;
         func_code_ff   <= 8'h00;
         count_ff       <= 16'd0;
         sub_off_ff     <= 16'd0;
         next_start_ff  <= 16'd0;
         rec_len_ff     <= 16'd0;
         obj_cnt_ff     <= 8'h00;
         walk_active_ff <= 1'b0;
         walk_match_ff  <= 1'b0;
         len_ovf_ff     <= 1'b0;
         for (int k = 0; k < 4; k++) addr_words_ff[k] <= 16'd0;
      end else if (s1_fire) begin
         byte_index_ff  <= byte_index_in;
         proto_id_ff    <= proto_id_in;
         mbap_len_ff    <= mbap_len_in;
         func_code_ff   <= func_code_in;
         count_ff       <= count_in;
         sub_off_ff     <= sub_off_in;
         next_start_ff  <= next_start_in;
         rec_len_ff     <= rec_len_in;
         obj_cnt_ff     <= obj_cnt_in;
         walk_active_ff <= walk_active_in;
         walk_match_ff  <= walk_match_in;
         len_ovf_ff     <= len_ovf_in;
         for (int k = 0; k < 4; k++) addr_words_ff[k] <= addr_words_in[k];
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_fire && s1_last_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire && s1_last_ff) begin
         verdict_ff <= (reason_cur != RSN_NONE);
         reason_ff  <= reason_cur;
         fcode_ff   <= fcode_cur;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_verdict_fail  = verdict_ff;
   assign rsp_fail_reason   = reason_ff;
   assign rsp_fcode         = fcode_ff;

   // checks
   `MTPF_ASSERT(a_verdict_reason, rsp_valid_ff |-> (verdict_ff == (reason_ff != RSN_NONE)), "verdict and reason disagree")
   `MTPF_ASSERT(a_short_fc, (rsp_valid_ff && reason_ff == RSN_SHORT) |-> (fcode_ff == 8'h00), "short packet with function code")
   `MTPF_ASSERT(a_clear_after_last, (s1_fire && s1_last_ff) |=> (byte_index_ff == 16'd0 && !len_ovf_ff), "packet state not cleared")
   `MTPF_ASSERT_NEVER(a_ovf_index, len_ovf_ff && (byte_index_ff != 16'hFFFF), "overflow flag without full index")

endmodule

FILE: bench/modbus_tcp_packet_filter_checker.sv
// Scoreboard for the Modbus/TCP packet filter: snoops req, rsp and csr beats,
// predicts each verdict and compares it. Depends on mtpf_pkg.
`timescale 1ns / 1ps
module modbus_tcp_packet_filter_checker
   import mtpf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   input  logic        req_last_byte,
   input  logic        req_response_dir,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic        rsp_verdict_fail,
   input  logic [2:0]  rsp_fail_reason,
   input  logic [7:0]  rsp_fcode,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_wdata,
   output int          mismatch_count,
   output int          verdicts_pending
);

   typedef struct packed {
      logic            fail;
      fail_reason_type rsn;
      logic [7:0]      fc;
   } verdict_type;

   verdict_type verdict_q[$];

   // register shadows
   logic [63:0] mask_lo, mask_hi;
   logic [15:0] win_min, win_max;

   // packet parse state
   logic [15:0] pos_q, proto_q, mbap_q, cnt8_q, rec_off_q, rec_base_q, rec_len_q;
   logic [7:0]  fc_q, obj_cnt_q;
   logic [3:0]  flags_q;            // 0 walk active, 1 walk matched, 2 overlong
   logic [15:0] words_q[4];

   task automatic clear_parse();
      pos_q = 0; proto_q = 0; mbap_q = 0; cnt8_q = 0; rec_off_q = 0;
      rec_base_q = 0; rec_len_q = 0; fc_q = 0; obj_cnt_q = 0; flags_q = 0;
      for (int i = 0; i < 4; i++) words_q[i] = 0;
   endtask

   // file-record sub-request walk and device-id object walk
   task automatic walk_pdu(input int unsigned j, input int unsigned b);
      int unsigned cnt, r, bp, rl, nb, s;
      cnt = words_q[0] >> 8;
      if (fc_q == FC_WRITE_FILE_RECORD) begin
         if (j == 0) begin
            rec_base_q = 0;
            rec_off_q = 0;
            flags_q = (flags_q & 4'b0100) | ((b >= 7) ? 4'b0001 : 4'b0000);
         end else if (flags_q[0]) begin
            r = rec_off_q;
            bp = rec_base_q;
            if (r == bp + 5) begin
               rec_len_q = b[15:0];
            end else if (r == bp + 6) begin
               rl = ((rec_len_q & 16'hFF) << 8) | b;
               nb = bp + 7 + 2 * rl;
               rec_len_q = rl[15:0];
               if (nb == cnt) flags_q = (flags_q | 4'b0010) & 4'b1110;
               else if (nb > cnt || cnt - nb < 7) flags_q = flags_q & 4'b1110;
               else rec_base_q = nb[15:0];
            end
            rec_off_q = rec_off_q + 16'd1;
         end
      end else if (fc_q == FC_MEI) begin
         if (j == 0) begin
            rec_base_q = 6;
            obj_cnt_q = 0;
         end else if (obj_cnt_q < words_q[2][7:0] && j == rec_base_q + 1) begin
            s = rec_base_q + 2 + b;
            rec_base_q = (s > 32'hFFFF) ? 16'hFFFF : s[15:0];
            obj_cnt_q = obj_cnt_q + 8'd1;
         end
      end
   endtask

   task automatic take_byte(input int unsigned p, input int unsigned b);
      int unsigned w;
      if (p == 2 || p == 3) proto_q = {proto_q[7:0], b[7:0]};
      else if (p == 4 || p == 5) mbap_q = {mbap_q[7:0], b[7:0]};
      else if (p == 7) fc_q = b[7:0];
      else if (p >= 8 && p <= 15) begin
         w = (p - 8) >> 1;
         if (p[0] == 1'b0) words_q[w] = {b[7:0], 8'h00};
         else words_q[w] = words_q[w] | {8'h00, b[7:0]};
      end else if (p == 16) cnt8_q = {8'h00, b[7:0]};
      if (p >= 8) walk_pdu(p - 8, b);
   endtask

   function automatic logic req_len_ok(input int unsigned p);
      int unsigned d0, d4;
      d0 = words_q[0] >> 8;
      d4 = words_q[2] >> 8;
      case (fc_q) inside
         FC_READ_COILS, FC_READ_DISCRETE, FC_READ_HOLDING, FC_READ_INPUT,
         FC_WRITE_COIL, FC_WRITE_REG, FC_DIAGNOSTIC: return p == 4;
         FC_READ_EXC_STATUS, FC_GET_COMM_COUNTER, FC_GET_COMM_LOG,
         FC_REPORT_SERVER_ID: return p == 0;
         FC_WRITE_COILS, FC_WRITE_REGS: return p >= 5 && p == d4 + 5;
         FC_MASK_WRITE_REG: return p == 6;
         FC_READ_WRITE_MULTI: return p >= 9 && p == 9 + cnt8_q;
         FC_READ_FIFO: return p == 2;
         FC_MEI: return p >= 1 && d0 == MEI_DEVICE_ID && p == 3;
         FC_READ_FILE_RECORD: return p >= 1 && d0 == p - 1 && d0 % 7 == 0;
         FC_WRITE_FILE_RECORD: return p >= 1 && d0 == p - 1 && flags_q[1];
         default: return 1'b1;
      endcase
   endfunction

   function automatic logic rsp_len_ok(input int unsigned p);
      int unsigned d0;
      d0 = words_q[0] >> 8;
      case (fc_q) inside
         FC_READ_COILS, FC_READ_DISCRETE, FC_GET_COMM_LOG, FC_READ_WRITE_MULTI:
            return p >= 1 && p == 1 + d0;
         FC_READ_HOLDING, FC_READ_INPUT: return p >= 1 && p == 1 + 2 * d0;
         FC_WRITE_COIL, FC_WRITE_REG, FC_DIAGNOSTIC, FC_GET_COMM_COUNTER,
         FC_WRITE_COILS, FC_WRITE_REGS: return p == 4;
         FC_READ_EXC_STATUS: return p == 1;
         FC_MASK_WRITE_REG: return p == 6;
         FC_READ_FIFO: return p >= 2 && p == 2 + words_q[0];
         FC_MEI: begin
            if (p < 6) return 1'b0;
            if (d0 == MEI_CANOPEN) return 1'b1;
            if (d0 != MEI_DEVICE_ID) return 1'b0;
            return obj_cnt_q == words_q[2][7:0] && rec_base_q == p;
         end
         default: return 1'b1;
      endcase
   endfunction

   function automatic logic in_window(input int unsigned start, input int unsigned qty);
      return start >= win_min && start + qty <= win_max;
   endfunction

   function automatic logic addr_allowed();
      case (fc_q) inside
         FC_READ_COILS, FC_READ_DISCRETE, FC_READ_HOLDING, FC_READ_INPUT,
         FC_WRITE_COILS, FC_WRITE_REGS: return in_window(words_q[0], words_q[1]);
         FC_WRITE_COIL, FC_WRITE_REG, FC_MASK_WRITE_REG: return in_window(words_q[0], 0);
         FC_READ_WRITE_MULTI:
            return in_window(words_q[0], words_q[1]) && in_window(words_q[2], words_q[3]);
         default: return 1'b1;
      endcase
   endfunction

   function automatic logic fc_masked();
      if (fc_q >= 1 && fc_q <= 64) return mask_lo[fc_q - 1];
      if (fc_q >= 65 && fc_q <= 128) return mask_hi[fc_q - 65];
      return 1'b0;
   endfunction

   // advance the parse by one beat; on the last beat queue the verdict
   task automatic predict_beat(input logic [7:0] b, input logic last, input logic resp);
      int unsigned len;
      verdict_type v;
      if (flags_q[2] || pos_q == 16'hFFFF) begin
         flags_q[2] = 1'b1;
      end else begin
         take_byte(pos_q, b);
         pos_q = pos_q + 16'd1;
      end
      if (last) begin
         len = flags_q[2] ? 32'h10000 : pos_q;
         v.rsn = RSN_NONE;
         v.fc = 8'h00;
         if (len < 8) v.rsn = RSN_SHORT;
         else begin
            v.fc = fc_q;
            if (proto_q != 0) v.rsn = RSN_PROTO_ID;
            else if (flags_q[2] || mbap_q != len - 6) v.rsn = RSN_MBAP_LEN;
            else if (resp) begin
               if (!rsp_len_ok(len - 8)) v.rsn = RSN_PDU_LEN;
            end
            else if (!req_len_ok(len - 8)) v.rsn = RSN_PDU_LEN;
            else if (fc_masked()) v.rsn = RSN_FUNC;
            else if (!addr_allowed()) v.rsn = RSN_ADDR;
         end
         v.fail = (v.rsn != RSN_NONE);
         verdict_q.push_back(v);
         clear_parse();
      end
   endtask

   always @(posedge clock) begin
      verdict_type e;
      if (reset) begin
         mask_lo = 0; mask_hi = 0; win_min = 0; win_max = 16'hFFFF;
         clear_parse();
         verdict_q.delete();
         mismatch_count = 0;
         verdicts_pending = 0;
      end else begin
         // shadow register writes
         if (csr_we) begin
            case (csr_index)
               CSR_MASK_LOW:  mask_lo = csr_wdata;
               CSR_MASK_HIGH: mask_hi = csr_wdata;
               CSR_ADDR_MIN:  win_min = csr_wdata[15:0];
               CSR_ADDR_MAX:  win_max = csr_wdata[15:0];
            endcase
         end
         if (req_valid && req_ready)
            predict_beat(req_rx_byte, req_last_byte, req_response_dir);
         // compare each result beat with the oldest verdict
         if (rsp_valid && rsp_ready) begin
            if (verdict_q.size() == 0) begin
               $display("%0t: unexpected verdict fail=%0d reason=%0d fc=%02h", $time,
                        rsp_verdict_fail, rsp_fail_reason, rsp_fcode);
               mismatch_count++;
            end else begin
               e = verdict_q.pop_front();
               if (rsp_verdict_fail !== e.fail) begin
                  $display("%0t: verdict_fail expected %0d actual %0d", $time,
                           e.fail, rsp_verdict_fail);
                  mismatch_count++;
               end
               if (rsp_fail_reason !== e.rsn) begin
                  $display("%0t: fail_reason expected %0d actual %0d", $time,
                           e.rsn, rsp_fail_reason);
                  mismatch_count++;
               end
               if (rsp_fcode !== e.fc) begin
                  $display("%0t: fcode expected %02h actual %02h", $time,
                           e.fc, rsp_fcode);
                  mismatch_count++;
               end
            end
         end
         verdicts_pending = verdict_q.size();
      end
   end

endmodule

FILE: bench/tb.sv
// Top of the packet filter bench: builds Modbus/TCP packets, drives them with
// random idling and gives the verdict. Depends on mtpf_pkg, the core and the checker.
`timescale 1ns / 1ps
module tb;
   import mtpf_pkg::*;

   localparam int CYCLE_LIMIT = 200000;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_ready;
   logic [7:0]  req_rx_byte = 0;
   logic        req_last_byte = 0;
   logic        req_response_dir = 0;
   logic        rsp_valid;
   logic        rsp_ready = 0;
   logic        rsp_verdict_fail;
   logic [2:0]  rsp_fail_reason;
   logic [7:0]  rsp_fcode;
   logic        csr_we = 0;
   logic [1:0]  csr_index = 0;
   logic [63:0] csr_wdata = 0;

   int          mismatch_count;
   int          verdicts_pending;
   int          cycle_count = 0;
   bit          calm = 0;          // no idling on either side
   logic [7:0]  pkt[$];
   logic [7:0]  pdu[$];

   modbus_tcp_packet_filter_core uut (.*);
   modbus_tcp_packet_filter_checker chk (.*);

   initial begin
      forever #10 clock = ~clock;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // result side: random stall bursts
   initial begin
      @(posedge clock);
      forever begin
         if (!calm && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 0;
            repeat ($urandom_range(1, 19)) @(posedge clock);
         end
         rsp_ready <= 1;
         repeat ($urandom_range(1, 30)) @(posedge clock);
      end
   end

   // drive one beat and hold it until accepted
   task automatic send_beat(input logic [7:0] b, input logic last, input logic dir);
      if (!calm && $urandom_range(0, 11) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_valid <= 1;
      req_rx_byte <= b;
      req_last_byte <= last;
      req_response_dir <= dir;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic send_packet(input logic dir);
      for (int i = 0; i < pkt.size(); i++)
         send_beat(pkt[i], i == pkt.size() - 1,
                   (i == pkt.size() - 1) ? dir : logic'($urandom_range(0, 1)));
   endtask

   task automatic add_word(input logic [15:0] w);
      pdu.push_back(w[15:8]);
      pdu.push_back(w[7:0]);
   endtask

   task automatic add_junk(input int n);
      repeat (n) pdu.push_back(8'($urandom));
   endtask

   function automatic logic [15:0] pick_addr();
      return ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 1200));
   endfunction

   function automatic logic [15:0] pick_qty();
      return ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 300));
   endfunction

   // well-formed request PDU for a function code
   task automatic build_request(input logic [7:0] fc);
      int n, rl, cnt;
      int rls[$];
      case (fc) inside
         FC_READ_COILS, FC_READ_DISCRETE, FC_READ_HOLDING, FC_READ_INPUT,
         FC_WRITE_COIL, FC_WRITE_REG, FC_DIAGNOSTIC: begin
            add_word(pick_addr());
            add_word(pick_qty());
         end
         FC_READ_EXC_STATUS, FC_GET_COMM_COUNTER, FC_GET_COMM_LOG, FC_REPORT_SERVER_ID: ;
         FC_WRITE_COILS, FC_WRITE_REGS: begin
            add_word(pick_addr());
            add_word(pick_qty());
            n = $urandom_range(0, 20);
            pdu.push_back(8'(n));
            add_junk(n);
         end
         FC_MASK_WRITE_REG: begin
            add_word(pick_addr());
            add_junk(4);
         end
         FC_READ_WRITE_MULTI: begin
            repeat (2) begin
               add_word(pick_addr());
               add_word(pick_qty());
            end
            n = $urandom_range(0, 20);
            pdu.push_back(8'(n));
            add_junk(n);
         end
         FC_READ_FIFO: add_word(pick_addr());
         FC_MEI: begin
            pdu.push_back(($urandom_range(0, 5) == 0) ? MEI_CANOPEN : MEI_DEVICE_ID);
            add_junk(2);
         end
         FC_READ_FILE_RECORD: begin
            n = $urandom_range(0, 5);
            pdu.push_back(8'(7 * n));
            add_junk(7 * n);
         end
         FC_WRITE_FILE_RECORD: begin
            // empty file record now and then
            if ($urandom_range(0, 9) == 0) begin
               pdu.push_back(8'h00);
            end else begin
               cnt = 0;
               repeat ($urandom_range(1, 4)) begin
                  rl = $urandom_range(0, 8);
                  rls.push_back(rl);
                  cnt += 7 + 2 * rl;
               end
               pdu.push_back(8'(cnt));
               foreach (rls[k]) begin
                  pdu.push_back(8'h06);
                  add_junk(4);
                  add_word(16'(rls[k]));
                  add_junk(2 * rls[k]);
               end
            end
         end
         default: add_junk($urandom_range(0, 10));
      endcase
   endtask

   // well-formed response PDU for a function code
   task automatic build_response(input logic [7:0] fc);
      int n, len;
      case (fc) inside
         FC_READ_COILS, FC_READ_DISCRETE, FC_GET_COMM_LOG, FC_READ_WRITE_MULTI: begin
            n = $urandom_range(0, 20);
            pdu.push_back(8'(n));
            add_junk(n);
         end
         FC_READ_HOLDING, FC_READ_INPUT: begin
            n = $urandom_range(0, 10);
            pdu.push_back(8'(n));
            add_junk(2 * n);
         end
         FC_WRITE_COIL, FC_WRITE_REG, FC_DIAGNOSTIC, FC_GET_COMM_COUNTER,
         FC_WRITE_COILS, FC_WRITE_REGS: add_junk(4);
         FC_READ_EXC_STATUS: add_junk(1);
         FC_MASK_WRITE_REG: add_junk(6);
         FC_READ_FIFO: begin
            n = $urandom_range(0, 10);
            add_word(16'(n));
            add_junk(n);
         end
         FC_MEI: begin
            if ($urandom_range(0, 3) == 0) begin
               pdu.push_back(MEI_CANOPEN);
               add_junk($urandom_range(5, 10));
            end else begin
               pdu.push_back(MEI_DEVICE_ID);
               add_junk(4);
               n = $urandom_range(0, 4);
               pdu.push_back(8'(n));
               repeat (n) begin
                  len = $urandom_range(0, 6);
                  pdu.push_back(8'($urandom));
                  pdu.push_back(8'(len));
                  add_junk(len);
               end
            end
         end
         default: add_junk($urandom_range(0, 10));
      endcase
   endtask

   // frame the PDU behind an MBAP header
   task automatic frame(input logic [7:0] fc);
      logic [15:0] mlen;
      mlen = 16'(pdu.size() + 2);
      pkt.delete();
      pkt.push_back(8'($urandom));
      pkt.push_back(8'($urandom));
      pkt.push_back(8'h00);
      pkt.push_back(8'h00);
      pkt.push_back(mlen[15:8]);
      pkt.push_back(mlen[7:0]);
      pkt.push_back(8'($urandom));
      pkt.push_back(fc);
      foreach (pdu[k]) pkt.push_back(pdu[k]);
   endtask

   task automatic build_packet(input logic [7:0] fc, input logic dir);
      pdu.delete();
      if (dir) build_response(fc);
      else build_request(fc);
      frame(fc);
   endtask

   // damage a packet: bit flip, truncation, extension, protocol id, length
   task automatic damage();
      int k;
      case ($urandom_range(0, 4))
         0: begin
            k = $urandom_range(0, pkt.size() - 1);
            pkt[k] = pkt[k] ^ (8'h01 << $urandom_range(0, 7));
         end
         1: begin
            k = $urandom_range(1, pkt.size());
            while (pkt.size() > k) void'(pkt.pop_back());
         end
         2: repeat ($urandom_range(1, 4)) pkt.push_back(8'($urandom));
         3: pkt[2 + $urandom_range(0, 1)] = 8'($urandom_range(1, 255));
         default: begin
            pkt[4] = 8'($urandom);
            pkt[5] = 8'($urandom);
         end
      endcase
   endtask

   function automatic logic [7:0] pick_fc();
      logic [7:0] ruled[19] = '{FC_READ_COILS, FC_READ_DISCRETE, FC_READ_HOLDING,
         FC_READ_INPUT, FC_WRITE_COIL, FC_WRITE_REG, FC_READ_EXC_STATUS, FC_DIAGNOSTIC,
         FC_GET_COMM_COUNTER, FC_GET_COMM_LOG, FC_WRITE_COILS, FC_WRITE_REGS,
         FC_REPORT_SERVER_ID, FC_READ_FILE_RECORD, FC_WRITE_FILE_RECORD,
         FC_MASK_WRITE_REG, FC_READ_WRITE_MULTI, FC_READ_FIFO, FC_MEI};
      if ($urandom_range(0, 7) == 0) return 8'($urandom);
      return ruled[$urandom_range(0, 18)];
   endfunction

   // register write while idle: drain verdicts, let the pipeline settle
   task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
      req_valid <= 0;
      @(posedge clock);
      while (verdicts_pending != 0) @(posedge clock);
      repeat (6) @(posedge clock);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 0;
   endtask

   task automatic set_regs(input logic [63:0] lo, input logic [63:0] hi,
                           input logic [15:0] wmin, input logic [15:0] wmax);
      write_reg(CSR_MASK_LOW, lo);
      write_reg(CSR_MASK_HIGH, hi);
      write_reg(CSR_ADDR_MIN, {48'h0, wmin});
      write_reg(CSR_ADDR_MAX, {48'h0, wmax});
   endtask

   initial begin
      logic [7:0] fc;
      logic       dir;
      logic [7:0] specials[6] = '{8'h00, FC_MASK_LAST, 8'h81, 8'hFF, 8'h40, 8'h41};
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      set_regs(64'h0, 64'h0, 16'h0000, 16'hFFFF);

      // directed: codes 1-18 (9, 10, 13, 14 as FIFO) and MEI both ways, file records, edge codes, framing faults
      for (int i = 0; i < 19; i++) begin
         fc = (i < 18) ? 8'(i + 1) : FC_MEI;
         if (fc == 8'h09 || fc == 8'h0A || fc == 8'h0D || fc == 8'h0E) fc = FC_READ_FIFO;
         build_packet(fc, 0);
         send_packet(0);
         build_packet(fc, 1);
         send_packet(1);
      end
      build_packet(FC_READ_FILE_RECORD, 0);
      send_packet(0);
      pdu.delete();
      pdu.push_back(8'h00);
      frame(FC_WRITE_FILE_RECORD);
      send_packet(0);
      foreach (specials[k]) begin
         build_packet(specials[k], k[0]);
         send_packet(k[0]);
      end
      pkt = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00};
      send_packet(0);
      build_packet(FC_READ_COILS, 0);
      pkt[3] = 8'h01;
      send_packet(0);
      build_packet(FC_READ_COILS, 0);
      pkt[5] = pkt[5] + 8'd1;
      send_packet(0);

      // random phases under changing register settings
      for (int ph = 0; ph < 10; ph++) begin
         case (ph)
            0: set_regs(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF, 16'hFFFF);
            1: set_regs(64'h0, 64'h0, 16'h0000, 16'h0000);
            2: set_regs(64'h8000_0000_0000_0001, 64'h8000_0000_0000_0001, 16'h0000, 16'hFFFF);
            default: set_regs({$urandom, $urandom} & {$urandom, $urandom},
                              {$urandom, $urandom} & {$urandom, $urandom},
                              16'($urandom_range(0, 600)), 16'($urandom_range(300, 65535)));
         endcase
         if (ph >= 8) calm = 1;
         for (int n = 0; n < 4; n++) begin
            dir = $urandom_range(0, 1);
            if ($urandom_range(0, 15) == 0) begin
               pkt.delete();
               repeat ($urandom_range(1, 30)) pkt.push_back(8'($urandom));
            end else begin
               build_packet(pick_fc(), dir);
               if ($urandom_range(0, 3) == 0) damage();
            end
            send_packet(dir);
         end
      end
      req_valid <= 0;
      calm = 1;

      @(posedge clock);
      while (verdicts_pending != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatch_count == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end

endmodule
